/* hw/rtl/voltmeter_display_controller_core_assert.svh */
// ----------------------------------------------------------------------------
// Voltmeter display controller assertion macros
// Concurrent assertion wrappers; compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef VOLTMETER_DISPLAY_CONTROLLER_CORE_ASSERT_SVH
`define VOLTMETER_DISPLAY_CONTROLLER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define VDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
    else $error(msg);
`define VDC_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
    (cond) |=> (prop)) else $error(msg);
`else
`define VDC_ASSERT(lbl, prop, msg)
`define VDC_ASSERT_NEXT(lbl, cond, prop, msg)
`endif
`endif

/* hw/rtl/vdc_pkg.sv */
// ----------------------------------------------------------------------------
// vdc_pkg
// Types, widths, codes and tables shared by the voltmeter display controller.
// ----------------------------------------------------------------------------
`default_nettype none

package vdc_pkg;

    // Averaging
    localparam int SAMPLES   = 8;
    localparam int ADC_W     = 10;
    localparam int ADC_MAX   = (1 << ADC_W) - 1;
    localparam int SUM_W     = $clog2(SAMPLES * ADC_MAX + 1);
    localparam int CNT_W     = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int CNT1_W    = CNT_W + 1;

    // Field widths
    localparam int FUNC_W    = 2;
    localparam int SW_W      = 4;
    localparam int MODE_W    = 2;
    localparam int SEL_W     = 2;
    localparam int NUM_LEVELS = 4;
    localparam int VAL_W     = 7;
    localparam int DUTY_W    = 7;
    localparam int SEG_W     = 8;
    localparam int PERIOD_W  = 16;
    localparam int DIGIT_W   = 4;

    // Config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL3 = 3'd4;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd25000;
    localparam logic [DUTY_W-1:0]   LEVEL0_RST = 7'd3;
    localparam logic [DUTY_W-1:0]   LEVEL1_RST = 7'd15;
    localparam logic [DUTY_W-1:0]   LEVEL2_RST = 7'd40;
    localparam logic [DUTY_W-1:0]   LEVEL3_RST = 7'd90;

    // Volt scaling: (avg*33 + 511) / 1023
    localparam int SCALE_W     = 16;
    localparam int SCALE_MUL   = 33;
    localparam int SCALE_ROUND = 511;
    localparam int DIV1023_SH  = 10;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;
    localparam logic [DUTY_W-1:0] DUTY_OFF  = 7'd0;

    // compare = period*duty/100 via reciprocal: ceil(2^30/100), exact below 2^23
    localparam int PROD_W    = PERIOD_W + DUTY_W;
    localparam int RECIP_W   = 24;
    localparam int WIDE_W    = PROD_W + RECIP_W;
    localparam int DIV_SHIFT = 30;
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

    localparam logic [SEG_W-1:0] DP_BIT = 8'h80;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE  = 2'd0,
        FUNC_REFRESH = 2'd1,
        FUNC_SWITCH  = 2'd2,
        FUNC_NONE    = 2'd3
    } t_func;

    typedef enum logic [MODE_W-1:0] {
        MODE_VOLT   = 2'd0,
        MODE_FREEZE = 2'd1,
        MODE_LEVEL  = 2'd2,
        MODE_HOLD   = 2'd3
    } t_mode;

    typedef struct packed {
        logic [PERIOD_W-1:0]                  period;
        logic [NUM_LEVELS-1:0][DUTY_W-1:0]    level;
    } t_cfg;

    typedef struct packed {
        logic [SEG_W-1:0]  segments;
        logic              digit_high;
        logic [DUTY_W-1:0] duty_percent;
        logic [VAL_W-1:0]  shown_value;
    } t_disp;

    function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'h0:    s = 8'h77;
            4'h1:    s = 8'h41;
            4'h2:    s = 8'h3B;
            4'h3:    s = 8'h6B;
            4'h4:    s = 8'h4D;
            4'h5:    s = 8'h6E;
            4'h6:    s = 8'h7E;
            4'h7:    s = 8'h43;
            4'h8:    s = 8'h7F;
            4'h9:    s = 8'h6F;
            4'hA:    s = 8'h5F;
            4'hB:    s = 8'h7C;
            4'hC:    s = 8'h36;
            4'hD:    s = 8'h79;
            4'hE:    s = 8'h3E;
            default: s = 8'h1E;
        endcase
        return s;
    endfunction

    // v/10 as (v*205)>>11, exact for seven-bit values
    function automatic logic [DIGIT_W-1:0] tens_of(input logic [VAL_W-1:0] v);
        logic [14:0] p;
        p = 15'(v) * 15'd205;
        return p[14:11];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/vdc_in_if.sv */
// ----------------------------------------------------------------------------
// vdc_in_if
// Input item channel: valid/ready with func, sample and switches.
// ----------------------------------------------------------------------------
`default_nettype none

interface vdc_in_if;
    import vdc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [FUNC_W-1:0]    func;
    logic [ADC_W-1:0]     sample;
    logic [SW_W-1:0]      switches;

    modport source (output valid, output func, output sample, output switches,
                    input ready);
    modport sink   (input valid, input func, input sample, input switches,
                    output ready);
endinterface

`default_nettype wire

/* hw/rtl/vdc_out_if.sv */
// ----------------------------------------------------------------------------
// vdc_out_if
// Result item channel: valid/ready with display and PWM fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface vdc_out_if;
    import vdc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [SEG_W-1:0]     segments;
    logic                 digit_high;
    logic [DUTY_W-1:0]    duty_percent;
    logic [PERIOD_W-1:0]  compare_count;
    logic [VAL_W-1:0]     shown_value;

    modport source (output valid, output segments, output digit_high,
                    output duty_percent, output compare_count, output shown_value,
                    input ready);
    modport sink   (input valid, input segments, input digit_high,
                    input duty_percent, input compare_count, input shown_value,
                    output ready);
endinterface

`default_nettype wire

/* hw/rtl/vdc_cfg.sv */
// ----------------------------------------------------------------------------
// vdc_cfg
// Configuration registers: PWM period and the four brightness levels.
// ----------------------------------------------------------------------------
`default_nettype none

module vdc_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [vdc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [vdc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output vdc_pkg::t_cfg                      o_cfg
);
    import vdc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PERIOD: n_cfg.period   = i_cfg_data[PERIOD_W-1:0];
                CFG_LEVEL0: n_cfg.level[0] = i_cfg_data[DUTY_W-1:0];
                CFG_LEVEL1: n_cfg.level[1] = i_cfg_data[DUTY_W-1:0];
                CFG_LEVEL2: n_cfg.level[2] = i_cfg_data[DUTY_W-1:0];
                CFG_LEVEL3: n_cfg.level[3] = i_cfg_data[DUTY_W-1:0];
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period   <= PERIOD_RST;
            r_cfg.level[0] <= LEVEL0_RST;
            r_cfg.level[1] <= LEVEL1_RST;
            r_cfg.level[2] <= LEVEL2_RST;
            r_cfg.level[3] <= LEVEL3_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* hw/rtl/vdc_state.sv */
// ----------------------------------------------------------------------------
// vdc_state
// Per-item state update: averaging, digit refresh, mode and duty; also
// registers period*duty for the compare stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "voltmeter_display_controller_core_assert.svh"

module vdc_state (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_load,
    input  wire vdc_pkg::t_func              i_func,
    input  wire logic [vdc_pkg::ADC_W-1:0]   i_sample,
    input  wire logic [vdc_pkg::SW_W-1:0]    i_switches,
    input  wire vdc_pkg::t_cfg               i_cfg,
    output vdc_pkg::t_disp                   o_disp,
    output logic [vdc_pkg::PROD_W-1:0]       o_prod
);
    import vdc_pkg::*;

    logic [SUM_W-1:0]  r_sum,    n_sum;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic [VAL_W-1:0]  r_value,  n_value;
    logic              r_toggle, n_toggle;
    t_mode             r_mode,   n_mode;
    logic [DUTY_W-1:0] r_duty,   n_duty;
    logic [SEG_W-1:0]  r_seg,    n_seg;
    logic              r_digit,  n_digit;
    logic [PROD_W-1:0] r_prod;

    // Sample path
    logic [SUM_W-1:0]   w_sum_acc;
    logic [CNT1_W-1:0]  w_cnt_inc;
    logic [ADC_W-1:0]   w_avg;
    logic [SCALE_W-1:0] w_x;
    logic [SCALE_W-1:0] w_q;

    // Refresh path
    logic [DIGIT_W-1:0] w_tens;
    logic [VAL_W-1:0]   w_ones;

    // Switch path
    t_mode              w_sw_mode;
    logic [SEL_W-1:0]   w_sel;
    logic [DUTY_W-1:0]  w_lv;

    assign w_sum_acc = r_sum + SUM_W'(i_sample);
    assign w_cnt_inc = CNT1_W'(r_count) + CNT1_W'(1);
    assign w_avg     = ADC_W'(w_sum_acc / SUM_W'(SAMPLES));
    assign w_x       = SCALE_W'(w_avg) * SCALE_W'(SCALE_MUL) + SCALE_W'(SCALE_ROUND);
    // floor(x/1023) = (x + (x>>10) + 1) >> 10 while the quotient stays below 1024
    assign w_q       = (w_x + (w_x >> DIV1023_SH) + SCALE_W'(1)) >> DIV1023_SH;

    assign w_tens    = tens_of(r_value);
    assign w_ones    = r_value - VAL_W'(w_tens) * VAL_W'(10);

    assign w_sw_mode = t_mode'(i_switches[MODE_W-1:0]);
    assign w_sel     = i_switches[MODE_W +: SEL_W];
    assign w_lv      = i_cfg.level[w_sel];

    always_comb begin
        n_sum    = r_sum;
        n_count  = r_count;
        n_value  = r_value;
        n_toggle = r_toggle;
        n_mode   = r_mode;
        n_duty   = r_duty;
        n_seg    = r_seg;
        n_digit  = r_digit;
        case (i_func)
            FUNC_SAMPLE: begin
                if (r_mode == MODE_VOLT) begin
                    if (w_cnt_inc >= CNT1_W'(SAMPLES)) begin
                        n_sum   = '0;
                        n_count = '0;
                        n_value = VAL_W'(w_q);
                    end else begin
                        n_sum   = w_sum_acc;
                        n_count = CNT_W'(w_cnt_inc);
                    end
                end
            end
            FUNC_REFRESH: begin
                n_toggle = ~r_toggle;
                n_digit  = r_toggle;
                if (r_toggle) begin
                    n_seg = seg_code(w_tens) | DP_BIT;
                end else begin
                    n_seg = seg_code(w_ones[DIGIT_W-1:0]);
                end
            end
            FUNC_SWITCH: begin
                case (w_sw_mode)
                    MODE_VOLT: begin
                        n_mode = MODE_VOLT;
                        n_duty = DUTY_OFF;
                    end
                    MODE_FREEZE: begin
                        n_mode = MODE_FREEZE;
                        n_duty = DUTY_FULL;
                    end
                    MODE_LEVEL: begin
                        n_mode  = MODE_LEVEL;
                        n_duty  = (w_lv > DUTY_FULL) ? DUTY_FULL : w_lv;
                        n_value = w_lv;
                    end
                    default: n_mode = r_mode;   // mode 3 keeps everything
                endcase
            end
            default: n_mode = r_mode;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_count  <= '0;
            r_value  <= '0;
            r_toggle <= 1'b0;
            r_mode   <= MODE_VOLT;
            r_duty   <= '0;
            r_seg    <= '0;
            r_digit  <= 1'b0;
        end else if (i_load) begin
            r_sum    <= n_sum;
            r_count  <= n_count;
            r_value  <= n_value;
            r_toggle <= n_toggle;
            r_mode   <= n_mode;
            r_duty   <= n_duty;
            r_seg    <= n_seg;
            r_digit  <= n_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= PROD_W'(i_cfg.period) * PROD_W'(n_duty);
        end
    end

    assign o_disp.segments     = r_seg;
    assign o_disp.digit_high   = r_digit;
    assign o_disp.duty_percent = r_duty;
    assign o_disp.shown_value  = r_value;
    assign o_prod              = r_prod;

    `VDC_ASSERT_NEXT(a_sample_ignored, i_load && i_func == FUNC_SAMPLE && r_mode != MODE_VOLT, $stable(r_sum) && $stable(r_count) && $stable(r_value), "sample changed state outside voltmeter mode")
    `VDC_ASSERT_NEXT(a_refresh_toggles, i_load && i_func == FUNC_REFRESH, r_toggle != $past(r_toggle) && r_digit == $past(r_toggle), "refresh did not alternate digits")
    `VDC_ASSERT(a_freeze_full, (r_mode == MODE_FREEZE) |-> (r_duty == DUTY_FULL), "freeze mode without full duty")
    `VDC_ASSERT(a_dp_on_high, r_digit == r_seg[SEG_W-1], "decimal point not tied to high digit")

endmodule

`default_nettype wire

/* hw/rtl/vdc_out.sv */
// ----------------------------------------------------------------------------
// vdc_out
// Result register: PWM compare value from the registered period*duty.
// ----------------------------------------------------------------------------
`default_nettype none

module vdc_out (
    input  wire logic                        i_clk,
    input  wire logic                        i_load,
    input  wire vdc_pkg::t_disp              i_disp,
    input  wire logic [vdc_pkg::PROD_W-1:0]  i_prod,
    output vdc_pkg::t_disp                   o_disp,
    output logic [vdc_pkg::PERIOD_W-1:0]     o_compare
);
    import vdc_pkg::*;

    t_disp               r_disp;
    logic [PERIOD_W-1:0] r_compare;
    logic [WIDE_W-1:0]   w_wide;

    // divide by 100 through the reciprocal multiply
    assign w_wide = WIDE_W'(i_prod) * WIDE_W'(RECIP_100);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_disp    <= i_disp;
            r_compare <= w_wide[DIV_SHIFT +: PERIOD_W];
        end
    end

    assign o_disp    = r_disp;
    assign o_compare = r_compare;

endmodule

`default_nettype wire

/* hw/rtl/voltmeter_display_controller_core.sv */
// ----------------------------------------------------------------------------
// voltmeter_display_controller_core
// Sample averaging, two-digit display refresh and LED PWM level control.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output accepts and returns exactly one
// result item for each, in order. An accepted item passes an input register,
// the state update stage (averaging, digit refresh, mode and duty, plus the
// period*duty product) and the result register, where the product is
// divided by 100 with a reciprocal multiply.
// Each stage holds independently, so input is still taken while a result
// waits downstream until all three stages are full.
// Configuration writes take effect on the next clock and are to be issued
// only while no items are in flight.
`default_nettype none

module voltmeter_display_controller_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [vdc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [vdc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    vdc_in_if.sink                              i_in,
    vdc_out_if.source                           o_out
);
    import vdc_pkg::*;

    // Input stage
    logic              r_s0_valid, n_s0_valid;
    logic [FUNC_W-1:0] r_s0_func;
    logic [ADC_W-1:0]  r_s0_sample;
    logic [SW_W-1:0]   r_s0_switches;

    logic              r_s1_valid, n_s1_valid;
    logic              r_out_valid, n_out_valid;

    logic              w_take;
    logic              w_adv1, w_load1;
    logic              w_adv2, w_load2;

    t_cfg              w_cfg;
    t_disp             w_s1_disp;
    logic [PROD_W-1:0] w_s1_prod;
    t_disp             w_out_disp;
    logic [PERIOD_W-1:0] w_compare;

    assign w_adv2  = !r_out_valid || o_out.ready;
    assign w_load2 = r_s1_valid && w_adv2;
    assign w_adv1  = !r_s1_valid || w_adv2;
    assign w_load1 = r_s0_valid && w_adv1;

    assign i_in.ready = !r_s0_valid || w_adv1;
    assign w_take     = i_in.valid && i_in.ready;

    assign n_s0_valid  = w_take  || (r_s0_valid && !w_adv1);
    assign n_s1_valid  = w_load1 || (r_s1_valid && !w_adv2);
    assign n_out_valid = w_load2 || (r_out_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s0_valid  <= n_s0_valid;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s0_func     <= i_in.func;
            r_s0_sample   <= i_in.sample;
            r_s0_switches <= i_in.switches;
        end
    end

    vdc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    vdc_state u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load1),
        .i_func     (t_func'(r_s0_func)),
        .i_sample   (r_s0_sample),
        .i_switches (r_s0_switches),
        .i_cfg      (w_cfg),
        .o_disp     (w_s1_disp),
        .o_prod     (w_s1_prod)
    );

    vdc_out u_out (
        .i_clk      (i_clk),
        .i_load     (w_load2),
        .i_disp     (w_s1_disp),
        .i_prod     (w_s1_prod),
        .o_disp     (w_out_disp),
        .o_compare  (w_compare)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.segments      = w_out_disp.segments;
    assign o_out.digit_high    = w_out_disp.digit_high;
    assign o_out.duty_percent  = w_out_disp.duty_percent;
    assign o_out.compare_count = w_compare;
    assign o_out.shown_value   = w_out_disp.shown_value;

endmodule

`default_nettype wire

/* bench/tb_voltmeter_display_controller_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_voltmeter_display_controller_core
// Checks averaging, digit refresh, mode/duty and PWM compare results of the
// voltmeter display controller against an in-bench model of the panel state,
// under directed cases, random traffic with idle and stall phases, and a long
// output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_voltmeter_display_controller_core;
    import vdc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 120;

    // Segment glyphs for digits 0..F, digit 0 in the low byte
    localparam logic [16*SEG_W-1:0] GLYPHS = {
        8'h1E, 8'h3E, 8'h79, 8'h36, 8'h7C, 8'h5F, 8'h6F, 8'h7F,
        8'h43, 8'h7E, 8'h6E, 8'h4D, 8'h6B, 8'h3B, 8'h41, 8'h77
    };

    typedef struct packed {
        logic [SEG_W-1:0]    segments;
        logic                digit_high;
        logic [DUTY_W-1:0]   duty_percent;
        logic [PERIOD_W-1:0] compare_count;
        logic [VAL_W-1:0]    shown_value;
    } t_panel;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    vdc_in_if  in_if ();
    vdc_out_if out_if ();

    voltmeter_display_controller_core u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Panel model state
    int unsigned       acc_sum;
    int unsigned       acc_count;
    logic [VAL_W-1:0]  shown_v;
    logic              next_high;
    t_mode             cur_mode;
    logic [DUTY_W-1:0] cur_duty;
    logic [SEG_W-1:0]  seg_q;
    logic              digit_q;
    logic [PERIOD_W-1:0] period_reg;
    logic [DUTY_W-1:0]   level_reg [NUM_LEVELS];

    t_panel panel_due [$];

    int fail_count;
    int items_sent;
    int results_checked;
    int averages_done;
    int refreshes_done;
    int config_sets;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int quiet_cycles;

    function automatic logic [SW_W-1:0] sw_word(input t_mode m, input logic [SEL_W-1:0] sel);
        return {sel, m};
    endfunction

    function automatic void predict_panel(input t_func f, input logic [ADC_W-1:0] adc,
                                          input logic [SW_W-1:0] sw);
        int unsigned avg;
        int unsigned tens;
        int unsigned ones;
        logic [DUTY_W-1:0] lv;
        t_panel p;
        case (f)
            FUNC_SAMPLE: begin
                if (cur_mode == MODE_VOLT) begin
                    acc_sum += adc;
                    acc_count++;
                    if (acc_count >= SAMPLES) begin
                        avg = acc_sum / SAMPLES;
                        shown_v = VAL_W'((avg * SCALE_MUL + SCALE_ROUND) / ADC_MAX);
                        acc_sum = 0;
                        acc_count = 0;
                        averages_done++;
                    end
                end
            end
            FUNC_REFRESH: begin
                tens = shown_v / 10;
                ones = shown_v % 10;
                if (!next_high) begin
                    digit_q = 1'b0;
                    seg_q = GLYPHS[ones*SEG_W +: SEG_W];
                end else begin
                    digit_q = 1'b1;
                    seg_q = GLYPHS[tens*SEG_W +: SEG_W] | DP_BIT;
                end
                next_high = !next_high;
                refreshes_done++;
            end
            FUNC_SWITCH: begin
                case (t_mode'(sw[MODE_W-1:0]))
                    MODE_VOLT: begin
                        cur_mode = MODE_VOLT;
                        cur_duty = DUTY_OFF;
                    end
                    MODE_FREEZE: begin
                        cur_mode = MODE_FREEZE;
                        cur_duty = DUTY_FULL;
                    end
                    MODE_LEVEL: begin
                        lv = level_reg[sw[SW_W-1:MODE_W]];
                        cur_mode = MODE_LEVEL;
                        cur_duty = (lv > DUTY_FULL) ? DUTY_FULL : lv;
                        shown_v = lv;
                    end
                    default: ;  // hold: previous mode stays
                endcase
            end
            default: ;
        endcase
        p.segments      = seg_q;
        p.digit_high    = digit_q;
        p.duty_percent  = cur_duty;
        p.compare_count = PERIOD_W'((32'(period_reg) * 32'(cur_duty)) / 100);
        p.shown_value   = shown_v;
        panel_due.push_back(p);
    endfunction

    task automatic push_item(input t_func f, input logic [ADC_W-1:0] adc,
                             input logic [SW_W-1:0] sw);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid    <= 1'b1;
        in_if.func     <= f;
        in_if.sample   <= adc;
        in_if.switches <= sw;
        do @(posedge clk); while (!in_if.ready);
        predict_panel(f, adc, sw);
        items_sent++;
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (panel_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // Writes all registers back to back; call only while idle
    task automatic apply_config(input logic [PERIOD_W-1:0] period,
                                input logic [DUTY_W-1:0] l0, input logic [DUTY_W-1:0] l1,
                                input logic [DUTY_W-1:0] l2, input logic [DUTY_W-1:0] l3);
        cfg_beat(CFG_PERIOD, CFG_DATA_W'(period));
        cfg_beat(CFG_LEVEL0, CFG_DATA_W'(l0));
        cfg_beat(CFG_LEVEL1, CFG_DATA_W'(l1));
        cfg_beat(CFG_LEVEL2, CFG_DATA_W'(l2));
        cfg_beat(CFG_LEVEL3, CFG_DATA_W'(l3));
        cfg_we <= 1'b0;
        period_reg   = period;
        level_reg[0] = l0;
        level_reg[1] = l1;
        level_reg[2] = l2;
        level_reg[3] = l3;
        config_sets++;
    endtask

    task automatic random_item();
        int r;
        t_mode m;
        r = $urandom_range(99);
        m = ($urandom_range(99) < 45) ? MODE_VOLT : t_mode'($urandom_range(3));
        if (r < 50)
            push_item(FUNC_SAMPLE, ADC_W'($urandom), SW_W'($urandom));
        else if (r < 75)
            push_item(FUNC_REFRESH, ADC_W'($urandom), SW_W'($urandom));
        else if (r < 94)
            push_item(FUNC_SWITCH, ADC_W'($urandom), sw_word(m, SEL_W'($urandom)));
        else
            push_item(FUNC_NONE, ADC_W'($urandom), SW_W'($urandom));
    endtask

    // Voltmeter mode, one full set of samples around a random level, then both digits
    task automatic average_burst();
        int base;
        int v;
        base = $urandom_range(0, ADC_MAX);
        push_item(FUNC_SWITCH, ADC_W'($urandom), sw_word(MODE_VOLT, SEL_W'($urandom)));
        repeat (SAMPLES) begin
            v = base + int'($urandom_range(64)) - 32;
            if (v < 0) v = 0;
            if (v > ADC_MAX) v = ADC_MAX;
            push_item(FUNC_SAMPLE, ADC_W'(v), SW_W'($urandom));
        end
        push_item(FUNC_REFRESH, ADC_W'($urandom), SW_W'($urandom));
        push_item(FUNC_REFRESH, ADC_W'($urandom), SW_W'($urandom));
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int n);
        int start;
        start = items_sent;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        while (items_sent - start < n) begin
            if ($urandom_range(99) < 25)
                average_burst();
            else
                random_item();
        end
        wait_idle();
    endtask

    task automatic test_directed_basics();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        push_item(FUNC_REFRESH, '0, '0);
        push_item(FUNC_REFRESH, '1, '1);
        repeat (SAMPLES) push_item(FUNC_SAMPLE, ADC_W'(ADC_MAX), '0);
        push_item(FUNC_REFRESH, '0, '0);
        push_item(FUNC_REFRESH, '0, '0);
        push_item(FUNC_NONE, '1, '1);
        // partial sum must survive freeze and level modes
        repeat (3) push_item(FUNC_SAMPLE, '0, '1);
        push_item(FUNC_SWITCH, '0, sw_word(MODE_FREEZE, 2'd3));
        push_item(FUNC_SAMPLE, ADC_W'(ADC_MAX), '0);
        push_item(FUNC_SWITCH, '0, sw_word(MODE_HOLD, 2'd2));
        push_item(FUNC_SWITCH, '0, sw_word(MODE_LEVEL, 2'd3));
        push_item(FUNC_SAMPLE, ADC_W'(512), '0);
        push_item(FUNC_SWITCH, '1, sw_word(MODE_VOLT, 2'd0));
        repeat (SAMPLES - 3) push_item(FUNC_SAMPLE, '0, '0);
        push_item(FUNC_REFRESH, '0, '0);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        logic [SEL_W-1:0] sel;
        apply_config(16'hFFFF, 7'd127, 7'd100, 7'd101, 7'd0);
        for (int i = 0; i < NUM_LEVELS; i++) begin
            sel = SEL_W'(i);
            push_item(FUNC_SWITCH, '0, sw_word(MODE_LEVEL, sel));
            push_item(FUNC_REFRESH, '0, '0);
            push_item(FUNC_REFRESH, '0, '0);
        end
        push_item(FUNC_SWITCH, '0, sw_word(MODE_FREEZE, 2'd0));
        wait_idle();
        apply_config(16'd1, 7'd1, 7'd99, 7'd50, 7'd100);
        for (int i = 0; i < NUM_LEVELS; i++) begin
            sel = SEL_W'(i);
            push_item(FUNC_SWITCH, '0, sw_word(MODE_LEVEL, sel));
        end
        push_item(FUNC_SWITCH, '0, sw_word(MODE_FREEZE, 2'd1));
        push_item(FUNC_SWITCH, '0, sw_word(MODE_VOLT, 2'd2));
        wait_idle();
    endtask

    task automatic test_random_phases();
        int pick;
        logic [PERIOD_W-1:0] period;
        for (int ph = 0; ph < 4; ph++) begin
            pick = $urandom_range(2);
            period = (pick == 0) ? 16'd1 : (pick == 1) ? 16'hFFFF
                   : PERIOD_W'($urandom_range(1, 16'hFFFF));
            apply_config(period, DUTY_W'($urandom), DUTY_W'($urandom),
                         DUTY_W'($urandom), DUTY_W'($urandom));
            case (ph)
                0: run_phase(0, 0, PHASE_ITEMS);
                1: run_phase(82, 0, PHASE_ITEMS);
                2: run_phase(0, 82, PHASE_ITEMS);
                default: run_phase(38, 38, PHASE_ITEMS);
            endcase
        end
    endtask

    // Output held off long enough for the pipeline to fill and stall the input
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        apply_config(PERIOD_RST, LEVEL0_RST, LEVEL1_RST, LEVEL2_RST, LEVEL3_RST);
        hold_left = 150;
        repeat (40) random_item();
        wait_idle();
    endtask

    function automatic void check_panel();
        t_panel e;
        if (panel_due.size() == 0) begin
            $error("result with no expected item waiting");
            fail_count++;
            return;
        end
        e = panel_due.pop_front();
        results_checked++;
        if (out_if.segments !== e.segments) begin
            $error("segments: expected %h, got %h", e.segments, out_if.segments);
            fail_count++;
        end
        if (out_if.digit_high !== e.digit_high) begin
            $error("digit_high: expected %0d, got %0d", e.digit_high, out_if.digit_high);
            fail_count++;
        end
        if (out_if.duty_percent !== e.duty_percent) begin
            $error("duty_percent: expected %0d, got %0d", e.duty_percent, out_if.duty_percent);
            fail_count++;
        end
        if (out_if.compare_count !== e.compare_count) begin
            $error("compare_count: expected %0d, got %0d", e.compare_count,
                   out_if.compare_count);
            fail_count++;
        end
        if (out_if.shown_value !== e.shown_value) begin
            $error("shown_value: expected %0d, got %0d", e.shown_value, out_if.shown_value);
            fail_count++;
        end
    endfunction

    // Result side: check, then pick ready for the next edge
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) check_panel();
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("no progress for %0d cycles", WATCHDOG_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        fail_count      = 0;
        items_sent      = 0;
        results_checked = 0;
        averages_done   = 0;
        refreshes_done  = 0;
        config_sets     = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_left       = 0;
        quiet_cycles    = 0;
        acc_sum   = 0;
        acc_count = 0;
        shown_v   = '0;
        next_high = 1'b0;
        cur_mode  = MODE_VOLT;
        cur_duty  = DUTY_OFF;
        seg_q     = '0;
        digit_q   = 1'b0;
        period_reg   = PERIOD_RST;
        level_reg[0] = LEVEL0_RST;
        level_reg[1] = LEVEL1_RST;
        level_reg[2] = LEVEL2_RST;
        level_reg[3] = LEVEL3_RST;

        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= CFG_PERIOD;
        cfg_data       <= '0;
        in_if.valid    <= 1'b0;
        in_if.func     <= FUNC_SAMPLE;
        in_if.sample   <= '0;
        in_if.switches <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_basics();
        test_register_extremes();
        test_random_phases();
        test_backpressure();

        wait_idle();
        repeat (8) @(posedge clk);

        $display("Ran %0d items, checked %0d results: %0d full averages, %0d digit refreshes,",
                 items_sent, results_checked, averages_done, refreshes_done);
        $display("%0d register sets incl. extremes, idle/stall phases and a long output hold.",
                 config_sets);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/vdc_pkg.sv
hw/rtl/vdc_in_if.sv
hw/rtl/vdc_out_if.sv
hw/rtl/vdc_cfg.sv
hw/rtl/vdc_state.sv
hw/rtl/vdc_out.sv
hw/rtl/voltmeter_display_controller_core.sv
bench/tb_voltmeter_display_controller_core.sv
